/* rtl/rgbp_pkg.sv */
// ----------------------------------------------------------------------------
// rgbp_pkg: shared types and constants of the grid cell bit packer
// Holds register codes, reset values and the queue entry that runs from the
// front classifier to the back packer.
// ----------------------------------------------------------------------------
package rgbp_pkg;

  // register widths and reset values
  localparam int GridW   = 10;
  localparam int BorderW = 4;
  localparam int FinderW = 7;
  localparam int CfgW    = 10;
  localparam int CfgIdxW = 2;

  localparam logic [GridW-1:0]   GridReset   = 10'd100;
  localparam logic [BorderW-1:0] BorderReset = 4'd1;
  localparam logic [FinderW-1:0] FinderReset = 7'd8;

  // field widths
  localparam int CoordW = 10;
  localparam int ChanW  = 8;
  localparam int ByteW  = 8;
  localparam int CellBits = 3;

  // defaults handed to the top level parameters
  localparam int MaxImageSideDefault = 1024;
  localparam int QueueDepthDefault   = 2;

  // register index codes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_CELLS   = 2'd0,
    CFG_BORDER_CELLS = 2'd1,
    CFG_FINDER_CELLS = 2'd2
  } cfg_idx_t;

  // classified pixel passed from front to back
  typedef struct packed {
    logic                frame_start;
    logic                use_cell;
    logic [CellBits-1:0] bits;
  } rgbp_entry_t;

endpackage

/* rtl/rgbp_front.sv */
// ----------------------------------------------------------------------------
// rgbp_front: pixel classifier
// Holds the configuration registers, decides whether a pixel is a data cell
// and thresholds its three channels into cell bits.
// ----------------------------------------------------------------------------
module rgbp_front #(
  parameter int MAX_IMAGE_SIDE = rgbp_pkg::MaxImageSideDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rgbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rgbp_pkg::CfgW-1:0]     cfg_data,
  input  logic                          frame_start,
  input  logic [rgbp_pkg::CoordW-1:0]   row,
  input  logic [rgbp_pkg::CoordW-1:0]   col,
  input  logic [rgbp_pkg::ChanW-1:0]    chan0,
  input  logic [rgbp_pkg::ChanW-1:0]    chan1,
  input  logic [rgbp_pkg::ChanW-1:0]    chan2,
  output rgbp_pkg::rgbp_entry_t         entry,
  output logic                          keep
);
  import rgbp_pkg::*;

  localparam logic [12:0] SideLimit = 13'(MAX_IMAGE_SIDE);

  logic [GridW-1:0]   grid_cells;
  logic [BorderW-1:0] border_cells;
  logic [FinderW-1:0] finder_cells;

  logic [CoordW-1:0] rr;
  logic [CoordW-1:0] cc;
  logic              in_image;
  logic              past_border;
  logic              in_grid;
  logic              top;
  logic              left;
  logic              bottom;
  logic              right;
  logic              use_cell;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cells   <= GridReset;
      border_cells <= BorderReset;
      finder_cells <= FinderReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_CELLS:   grid_cells   <= cfg_data[GridW-1:0];
        CFG_BORDER_CELLS: border_cells <= cfg_data[BorderW-1:0];
        CFG_FINDER_CELLS: finder_cells <= cfg_data[FinderW-1:0];
        default: ;
      endcase
    end
  end

  // position relative to the data grid
  always_comb begin
    in_image    = ({3'b0, row} < SideLimit) && ({3'b0, col} < SideLimit);
    past_border = (row >= CoordW'(border_cells)) && (col >= CoordW'(border_cells));
    rr          = row - CoordW'(border_cells);
    cc          = col - CoordW'(border_cells);
    in_grid     = (rr < grid_cells) && (cc < grid_cells);
    top         = rr < CoordW'(finder_cells);
    left        = cc < CoordW'(finder_cells);
    bottom      = ({1'b0, rr} + 11'(finder_cells)) >= 11'(grid_cells);
    right       = ({1'b0, cc} + 11'(finder_cells)) >= 11'(grid_cells);
    use_cell    = in_image && past_border && in_grid
                  && !((top && left) || (bottom && left) || (top && right));
  end

  // channel thresholds at half scale, chan0 first
  always_comb begin
    entry.frame_start = frame_start;
    entry.use_cell    = use_cell;
    entry.bits        = {chan2[ChanW-1], chan1[ChanW-1], chan0[ChanW-1]};
    keep              = frame_start || use_cell;
  end

endmodule

/* rtl/rgbp_queue.sv */
// ----------------------------------------------------------------------------
// rgbp_queue: short queue between classifier and packer
// Register based first-in first-out buffer of classified pixels.
// ----------------------------------------------------------------------------
module rgbp_queue #(
  parameter int DEPTH = rgbp_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rgbp_pkg::rgbp_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output rgbp_pkg::rgbp_entry_t head_entry
);
  import rgbp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  rgbp_entry_t          slots [DEPTH];
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [CntW-1:0]      count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == DepthCnt);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (rst) count <= DepthCnt)
    else $error("queue count above depth");
  // a lone push grows the count by one
  assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

/* rtl/rgbp_back.sv */
// ----------------------------------------------------------------------------
// rgbp_back: bit packer
// Appends the three bits of each data cell to the partial byte and hands
// out a byte, earliest bit in bit zero, when eight bits are complete.
// ----------------------------------------------------------------------------
module rgbp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  rgbp_pkg::rgbp_entry_t        head_entry,
  output logic                         pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rgbp_pkg::ByteW-1:0]   m_axis_tdata
);
  import rgbp_pkg::*;

  localparam int ExtW = ByteW + CellBits;

  logic [ByteW-1:0] pending_bits;
  logic [2:0]       bit_count;

  logic [ByteW-1:0] pend_base;
  logic [2:0]       cnt_base;
  logic [ExtW-1:0]  ext;
  logic [3:0]       cnt_sum;
  logic             emit;

  // merge the cell bits into the partial byte
  always_comb begin
    pend_base = head_entry.frame_start ? '0 : pending_bits;
    cnt_base  = head_entry.frame_start ? '0 : bit_count;
    ext       = {{CellBits{1'b0}}, pend_base} | (ExtW'(head_entry.bits) << cnt_base);
    cnt_sum   = {1'b0, cnt_base} + 4'(CellBits);
    emit      = head_entry.use_cell && cnt_sum[3];
    pop       = head_valid && (!emit || !m_axis_tvalid || m_axis_tready);
  end

  // partial byte state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits <= '0;
      bit_count    <= '0;
    end else if (pop) begin
      if (!head_entry.use_cell) begin
        pending_bits <= pend_base;
        bit_count    <= cnt_base;
      end else if (emit) begin
        pending_bits <= ByteW'(ext[ExtW-1:ByteW]);
        bit_count    <= cnt_sum[2:0];
      end else begin
        pending_bits <= ext[ByteW-1:0];
        bit_count    <= cnt_sum[2:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      m_axis_tdata <= ext[ByteW-1:0];
    end
  end

`ifndef SYNTHESIS
  // a completed byte shows up in the output register
  assert property (@(posedge clk) disable iff (rst)
    pop && emit |=> m_axis_tvalid && m_axis_tdata == $past(ext[ByteW-1:0]))
    else $error("completed byte not presented");
  // bits above the fill count stay clear
  assert property (@(posedge clk) disable iff (rst) (pending_bits >> bit_count) == '0)
    else $error("stray bits above fill count");
`endif

endmodule

/* rtl/rgb_grid_cell_bit_packer.sv */
// ----------------------------------------------------------------------------
// rgb_grid_cell_bit_packer: color grid code cell to byte packer
// Turns raster pixels of a color grid code into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one pixel per request, row, column and three
//   channel values in tdata, frame start flag in tuser. Pixels inside the
//   data grid and outside the three finder corners give three bits each,
//   one per channel (set when the channel is 128 or more).
//   Output stream m_axis_*: one packed byte per request, earliest bit in
//   bit zero, sent as soon as its eighth bit is in.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 grid cells, 1 border cells, 2 finder cells); other indexes are
//   ignored. Write only while no pixel is in flight.
//   Throughput: one pixel per cycle while the queue is not full, limited by the single packer step.
//   Path: a pixel that completes a byte is held in the queue, then its byte in the output register.
//   Reset: registers return to grid 100, border 1, finder 8, the partial
//   byte is cleared and the output is empty.
//   Stall: a stalled output holds its byte; the queue between classifier
//   and packer keeps taking pixels until it is full, then tready drops.
// ----------------------------------------------------------------------------
module rgb_grid_cell_bit_packer #(
  parameter int MAX_IMAGE_SIDE = rgbp_pkg::MaxImageSideDefault,
  parameter int QUEUE_DEPTH    = rgbp_pkg::QueueDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // row, col, chan0, chan1, chan2, zero pad
  input  logic                          s_axis_tuser,  // frame_start
  // byte output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rgbp_pkg::ByteW-1:0]    m_axis_tdata,  // data_byte
  // configuration
  input  logic                          cfg_we,
  input  logic [rgbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rgbp_pkg::CfgW-1:0]     cfg_data
);
  import rgbp_pkg::*;

  rgbp_entry_t entry;
  rgbp_entry_t head_entry;
  logic        keep;
  logic        full;
  logic        head_valid;
  logic        pop;

  assign s_axis_tready = !full;

  // classifier
  rgbp_front #(
    .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame_start (s_axis_tuser),
    .row         (s_axis_tdata[9:0]),
    .col         (s_axis_tdata[19:10]),
    .chan0       (s_axis_tdata[27:20]),
    .chan1       (s_axis_tdata[35:28]),
    .chan2       (s_axis_tdata[43:36]),
    .entry       (entry),
    .keep        (keep)
  );

  // queue of classified pixels
  rgbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_axis_tvalid && keep),
    .push_entry (entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // packer and output register
  rgbp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
